// File: rtl/core/gmd_pkg.sv
// Shared types and constants for the greedy minimum-distance point filter.
package gmd_pkg;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int DIST_W  = 16;
	localparam int LIM_W   = 2 * DIST_W;
	localparam int TOTAL_W = 9;
	localparam int ENTRY_W = 3 * COORD_W;

	localparam logic [DIST_W-1:0] DIST_RESET = 16'd256;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      start_set;
	} pt_req_t;

	typedef struct packed {
		logic               keep;
		logic [TOTAL_W-1:0] kept_total;
		logic               store_overflow;
	} res_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} gmd_state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic commit;
	} gmd_cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
		logic busy;
	} gmd_status_t;

endpackage

// File: rtl/core/greedy_min_distance_point_filter.sv
// Top level of the greedy minimum-distance point filter.
// Usage:
//   Points arrive on the pt channel (pt_valid, pt_stall, pt) one request at a
//   time; each gives one result on the res channel (res_valid, res_stall, res).
//   A point is kept when its squared distance to every kept point of the
//   current set is at least min_distance squared; start_set empties the set.
//   min_distance must be written through wr_en / wr_data only while the block
//   is idle; the block itself does not enforce this. The store is scanned one
//   entry per cycle from the kept-point RAM read port, and a new point is
//   accepted only once the previous one has been committed.
//   Results sit in an output register; the next point is accepted while a
//   result waits, and its result is held back until the waiting one is taken.
//   While the receiver stalls, res holds steady.
//   Reset clears the kept count, restores min_distance to 1.0 angstrom and
//   drops any pending result; the store contents are not cleared.
module greedy_min_distance_point_filter #(
	parameter int MAX_KEPT = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pt_valid,
	output logic                       pt_stall,
	input  gmd_pkg::pt_req_t           pt,
	output logic                       res_valid,
	input  logic                       res_stall,
	output gmd_pkg::res_rsp_t          res,
	input  logic                       wr_en,
	input  logic [gmd_pkg::DIST_W-1:0] wr_data
);

	gmd_pkg::gmd_cmd_t    cmd;
	gmd_pkg::gmd_status_t status;

	gmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status   (status),
		.cmd      (cmd)
	);

	gmd_dp #(
		.MAX_KEPT(MAX_KEPT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt),
		.wr_en  (wr_en),
		.wr_data(wr_data),
		.cmd    (cmd),
		.status (status),
		.res    (res)
	);

endmodule

// File: rtl/core/gmd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/gmd_ctrl.sv
// Controller state machine for the point filter: accept, scan, drain, commit.
module gmd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pt_valid,
	output logic                 pt_stall,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  gmd_pkg::gmd_status_t status,
	output gmd_pkg::gmd_cmd_t    cmd
);

	gmd_pkg::gmd_state_t state_q, state_d;
	logic                res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		pt_stall = 1'b1;
		unique case (state_q)
			gmd_pkg::ST_IDLE: begin
				pt_stall = 1'b0;
				if (pt_valid) begin
					cmd.accept = 1'b1;
					state_d    = gmd_pkg::ST_SCAN;
				end
			end
			gmd_pkg::ST_SCAN: begin
				if (status.empty) begin
					state_d = gmd_pkg::ST_FINISH;
				end else begin
					cmd.issue = 1'b1;
					if (status.last) begin
						state_d = gmd_pkg::ST_DRAIN;
					end
				end
			end
			gmd_pkg::ST_DRAIN: begin
				if (!status.busy) begin
					state_d = gmd_pkg::ST_FINISH;
				end
			end
			gmd_pkg::ST_FINISH: begin
				if (!res_valid_q || !res_stall) begin
					cmd.commit = 1'b1;
					state_d    = gmd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gmd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

// File: rtl/core/gmd_dp.sv
// Datapath for the point filter: kept store, distance pipeline and result register.
module gmd_dp #(
	parameter int MAX_KEPT = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gmd_pkg::pt_req_t                   pt,
	input  logic                               wr_en,
	input  logic [gmd_pkg::DIST_W-1:0]         wr_data,
	input  gmd_pkg::gmd_cmd_t                  cmd,
	output gmd_pkg::gmd_status_t               status,
	output gmd_pkg::res_rsp_t                  res
);

	localparam int ADDR_W = $clog2(MAX_KEPT);
	localparam int CNT_W  = $clog2(MAX_KEPT + 1);

	logic [gmd_pkg::DIST_W-1:0]  min_q;
	logic [gmd_pkg::LIM_W-1:0]   lim_q;
	gmd_pkg::pt_req_t            p_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            count_next;
	logic [ADDR_W-1:0]           idx_q;
	logic                        hit_q;
	logic                        full;
	logic                        store_we;
	logic                        v_s1, v_s2, v_s3;
	logic [gmd_pkg::ENTRY_W-1:0] entry_s1;
	logic [gmd_pkg::COORD_W-1:0] kx, ky, kz;
	logic [gmd_pkg::DIFF_W-1:0]  dx, dy, dz;
	logic [gmd_pkg::DIFF_W-1:0]  ax_s2, ay_s2, az_s2;
	logic [gmd_pkg::SQ_W-1:0]    sqx_s3, sqy_s3, sqz_s3;
	logic [gmd_pkg::SUM_W-1:0]   sum;
	gmd_pkg::res_rsp_t           res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= gmd_pkg::DIST_RESET;
			lim_q <= gmd_pkg::LIM_W'(gmd_pkg::DIST_RESET) * gmd_pkg::LIM_W'(gmd_pkg::DIST_RESET);
		end else begin
			if (wr_en) begin
				min_q <= wr_data;
			end
			lim_q <= gmd_pkg::LIM_W'(min_q) * gmd_pkg::LIM_W'(min_q);
		end
	end

	assign full       = (count_q == CNT_W'(MAX_KEPT));
	assign store_we   = cmd.commit && !hit_q && !full;
	assign count_next = store_we ? count_q + CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				if (pt.start_set) begin
					count_q <= '0;
				end
			end else begin
				if (cmd.issue) begin
					idx_q <= idx_q + ADDR_W'(1);
				end
				if (v_s3 && (sum < gmd_pkg::SUM_W'(lim_q))) begin
					hit_q <= 1'b1;
				end
				if (cmd.commit) begin
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_q <= pt;
		end
	end

	gmd_ram #(
		.WIDTH(gmd_pkg::ENTRY_W),
		.DEPTH(MAX_KEPT)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata({p_q.pos_x, p_q.pos_y, p_q.pos_z}),
		.raddr(idx_q),
		.rdata(entry_s1)
	);

	assign {kx, ky, kz} = entry_s1;

	assign dx = {p_q.pos_x[gmd_pkg::COORD_W-1], p_q.pos_x} - {kx[gmd_pkg::COORD_W-1], kx};
	assign dy = {p_q.pos_y[gmd_pkg::COORD_W-1], p_q.pos_y} - {ky[gmd_pkg::COORD_W-1], ky};
	assign dz = {p_q.pos_z[gmd_pkg::COORD_W-1], p_q.pos_z} - {kz[gmd_pkg::COORD_W-1], kz};

	always_ff @(posedge clk) begin
		ax_s2  <= dx[gmd_pkg::DIFF_W-1] ? (~dx + gmd_pkg::DIFF_W'(1)) : dx;
		ay_s2  <= dy[gmd_pkg::DIFF_W-1] ? (~dy + gmd_pkg::DIFF_W'(1)) : dy;
		az_s2  <= dz[gmd_pkg::DIFF_W-1] ? (~dz + gmd_pkg::DIFF_W'(1)) : dz;
		sqx_s3 <= gmd_pkg::SQ_W'(ax_s2) * gmd_pkg::SQ_W'(ax_s2);
		sqy_s3 <= gmd_pkg::SQ_W'(ay_s2) * gmd_pkg::SQ_W'(ay_s2);
		sqz_s3 <= gmd_pkg::SQ_W'(az_s2) * gmd_pkg::SQ_W'(az_s2);
	end

	assign sum = gmd_pkg::SUM_W'(sqx_s3) + gmd_pkg::SUM_W'(sqy_s3) + gmd_pkg::SUM_W'(sqz_s3);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.keep           <= !hit_q;
			res_q.kept_total     <= gmd_pkg::TOTAL_W'(count_next);
			res_q.store_overflow <= !hit_q && full;
		end
	end

	assign res = res_q;

	assign status.empty = (count_q == '0);
	assign status.last  = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
	assign status.busy  = v_s1 || v_s2 || v_s3;

endmodule
